// ===== rtl/hjs_pkg.sv =====
// ----------------------------------------------------------------------------
// hjs_pkg: shared types and constants of the Jacobi heat stencil sweep unit
// Field widths, register indexes, reset values and the Q15.16 rounding helper.
// ----------------------------------------------------------------------------
package hjs_pkg;

  localparam int DATA_W   = 32;
  localparam int GRID_W   = 11;
  localparam int ALPHA_W  = 16;
  localparam int ROWCOL_W = 10;
  localparam int FRAC_W   = 16;
  localparam int SUM_W    = DATA_W + 2;
  localparam int PROD_W   = SUM_W + ALPHA_W + 1;
  localparam int Q_W      = PROD_W - FRAC_W;
  localparam int SLOTS    = 3;
  localparam int CNT_W    = 2;

  localparam logic [GRID_W-1:0]  GRID_RESET  = 11'd64;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd16384;
  localparam logic [DATA_W-1:0]  HOT_RESET   = 32'd6553600;
  localparam logic [DATA_W-1:0]  COLD_RESET  = 32'd0;
  localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(32768);
  localparam logic [DATA_W-1:0]  SAT_MAX     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]  SAT_MIN     = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_ALPHA_GAIN = 2'd1,
    REG_HOT_TEMP   = 2'd2,
    REG_COLD_TEMP  = 2'd3
  } cfg_reg_e;

  // Where the value of one result comes from.
  typedef enum logic [1:0] {
    SRC_INTERIOR = 2'd0,
    SRC_BOTTOM   = 2'd1,
    SRC_HELD     = 2'd2
  } src_e;

  typedef struct packed {
    logic [GRID_W-1:0]  grid_size;
    logic [ALPHA_W-1:0] alpha;
    logic [DATA_W-1:0]  hot;
    logic [DATA_W-1:0]  cold;
  } cfg_t;

  typedef struct packed {
    src_e                src;
    logic [ROWCOL_W-1:0] row;
    logic [ROWCOL_W-1:0] col;
    logic                done;
  } slot_t;

  typedef struct packed {
    slot_t [SLOTS-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic              upd_held;
  } desc_t;

  typedef struct packed {
    desc_t             desc;
    logic [SUM_W-1:0]  sum_int;
    logic [SUM_W-1:0]  sum_bot;
  } front_item_t;

  // Add one half LSB, floor to Q15.16 and saturate to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] round_sat(input logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0] biased;
    logic [Q_W-1:0]    q;
    logic              fits;
    biased = prod + ROUND_HALF;
    q      = biased[PROD_W-1:FRAC_W];
    fits   = (&q[Q_W-1:DATA_W-1]) | (~|q[Q_W-1:DATA_W-1]);
    if (fits) begin
      return q[DATA_W-1:0];
    end
    return q[Q_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

endpackage

// ===== rtl/hjs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hjs_cfg_regs: configuration register file
// Decodes writes on the configuration channel and flags a grid size write.
// ----------------------------------------------------------------------------
module hjs_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [hjs_pkg::DATA_W-1:0] cfg_data_i,
  output hjs_pkg::cfg_t              cfg_o,
  output logic                       grid_wr_o
);

  logic [hjs_pkg::GRID_W-1:0]  grid_q, grid_d;
  logic [hjs_pkg::ALPHA_W-1:0] alpha_q, alpha_d;
  logic [hjs_pkg::DATA_W-1:0]  hot_q, hot_d;
  logic [hjs_pkg::DATA_W-1:0]  cold_q, cold_d;
  logic                        grid_wr;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    grid_d  = grid_q;
    alpha_d = alpha_q;
    hot_d   = hot_q;
    cold_d  = cold_q;
    grid_wr = 1'b0;
    if (cfg_valid_i) begin
      unique case (hjs_pkg::cfg_reg_e'(cfg_index_i))
        hjs_pkg::REG_GRID_SIZE: begin
          grid_d  = cfg_data_i[hjs_pkg::GRID_W-1:0];
          grid_wr = 1'b1;
        end
        hjs_pkg::REG_ALPHA_GAIN: alpha_d = cfg_data_i[hjs_pkg::ALPHA_W-1:0];
        hjs_pkg::REG_HOT_TEMP:   hot_d   = cfg_data_i;
        hjs_pkg::REG_COLD_TEMP:  cold_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q  <= hjs_pkg::GRID_RESET;
      alpha_q <= hjs_pkg::ALPHA_RESET;
      hot_q   <= hjs_pkg::HOT_RESET;
      cold_q  <= hjs_pkg::COLD_RESET;
    end else begin
      grid_q  <= grid_d;
      alpha_q <= alpha_d;
      hot_q   <= hot_d;
      cold_q  <= cold_d;
    end
  end

  assign cfg_o.grid_size = grid_q;
  assign cfg_o.alpha     = alpha_q;
  assign cfg_o.hot       = hot_q;
  assign cfg_o.cold      = cold_q;
  assign grid_wr_o       = grid_wr;

endmodule

// ===== rtl/hjs_line_front.sv =====
// ----------------------------------------------------------------------------
// hjs_line_front: raster counters, line buffers and operand stage
// Keeps the two previous rows, gathers the four neighbors of the interior
// and bottom cells, sums them and plans the results each item causes.
// ----------------------------------------------------------------------------
module hjs_line_front #(
  parameter int GRID_MAX = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hjs_pkg::cfg_t              cfg_i,
  input  logic                       grid_wr_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [hjs_pkg::DATA_W-1:0] cell_temperature_i,
  output logic                       item_valid_o,
  output hjs_pkg::front_item_t       item_o,
  input  logic                       item_ready_i
);

  localparam int AW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int NW = $clog2(GRID_MAX + 1);
  localparam int CW = (NW > hjs_pkg::GRID_W) ? NW : hjs_pkg::GRID_W;

  logic [hjs_pkg::DATA_W-1:0] upper_mem  [GRID_MAX];
  logic [hjs_pkg::DATA_W-1:0] middle_mem [GRID_MAX];

  logic [AW-1:0] col_q, col_d, row_q, row_d;
  logic          pend_q, pend_d;
  logic [hjs_pkg::DATA_W-1:0] left_q, x1_q, x2_q;
  logic [hjs_pkg::DATA_W-1:0] rd_up_q, rd_mid0_q, rd_mid1_q;
  logic [AW-1:0] rd_addr, rd_addr1;

  logic          s1_v_q, s1_v_d, s1_ready, accept, keep;
  hjs_pkg::front_item_t s1_q, item_d;

  logic [CW-1:0] grid_w;
  logic [NW-1:0] n, nm1, nm2, col_n, row_n, c_inc, r_inc;
  logic          int_en, bot_en, last_col;
  logic [hjs_pkg::DATA_W-1:0] up;
  logic [hjs_pkg::CNT_W-1:0]  k;

  function automatic hjs_pkg::slot_t make_slot(input hjs_pkg::src_e src,
                                               input logic [NW-1:0] row,
                                               input logic [NW-1:0] col,
                                               input logic [NW-1:0] last);
    hjs_pkg::slot_t s;
    s.src  = src;
    s.row  = hjs_pkg::ROWCOL_W'(row);
    s.col  = hjs_pkg::ROWCOL_W'(col);
    s.done = (row == last) && (col == last);
    return s;
  endfunction

  // Effective edge length: the written size clamped to the supported range.
  assign grid_w = CW'(cfg_i.grid_size);
  always_comb begin
    if (grid_w < CW'(3)) begin
      n = NW'(3);
    end else if (grid_w > CW'(GRID_MAX)) begin
      n = NW'(GRID_MAX);
    end else begin
      n = NW'(grid_w);
    end
  end

  assign nm1   = n - NW'(1);
  assign nm2   = n - NW'(2);
  assign col_n = NW'(col_q);
  assign row_n = NW'(row_q);
  assign c_inc = col_n + NW'(1);
  assign r_inc = row_n + NW'(1);

  assign s1_ready   = !s1_v_q || item_ready_i;
  assign accept     = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  assign int_en   = (row_n != '0) && (col_n != '0) && (col_n <= nm2);
  assign bot_en   = (row_n == nm1) && (col_n >= NW'(2));
  assign last_col = (col_n == nm1);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (grid_wr_i) begin
      col_d  = '0;
      row_d  = '0;
      pend_d = 1'b0;
    end else if (accept) begin
      if (c_inc == n) begin
        col_d = '0;
        row_d = (r_inc == n) ? '0 : AW'(r_inc);
      end else begin
        col_d = AW'(c_inc);
      end
      if (bot_en) begin
        pend_d = !last_col;
      end
    end
  end

  // The line buffers are read ahead, into registers, at the column of the next item.
  assign rd_addr  = col_d;
  assign rd_addr1 = rd_addr + AW'(1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      upper_mem[col_q]  <= rd_mid0_q;
      middle_mem[col_q] <= cell_temperature_i;
    end
    rd_up_q   <= upper_mem[rd_addr];
    rd_mid0_q <= middle_mem[rd_addr];
    rd_mid1_q <= middle_mem[rd_addr1];
  end

  assign up = (row_n == NW'(1)) ? cfg_i.hot : rd_up_q;

  always_comb begin
    item_d = '0;
    k      = '0;
    item_d.sum_int = hjs_pkg::SUM_W'($signed(up)) +
                     hjs_pkg::SUM_W'($signed(cell_temperature_i)) +
                     hjs_pkg::SUM_W'($signed(left_q)) +
                     hjs_pkg::SUM_W'($signed(rd_mid1_q));
    // The upper neighbor of a bottom cell is the left value of this column.
    item_d.sum_bot = hjs_pkg::SUM_W'($signed(left_q)) +
                     hjs_pkg::SUM_W'($signed(cfg_i.cold)) +
                     hjs_pkg::SUM_W'($signed(x2_q)) +
                     hjs_pkg::SUM_W'($signed(cell_temperature_i));
    if (int_en) begin
      if (col_n == NW'(1)) begin
        item_d.desc.slot[k] = make_slot(hjs_pkg::SRC_INTERIOR, row_n - NW'(1), '0, nm1);
        k = k + hjs_pkg::CNT_W'(1);
      end
      item_d.desc.slot[k] = make_slot(hjs_pkg::SRC_INTERIOR, row_n - NW'(1), col_n, nm1);
      k = k + hjs_pkg::CNT_W'(1);
      if (col_n == nm2) begin
        item_d.desc.slot[k] = make_slot(hjs_pkg::SRC_INTERIOR, row_n - NW'(1), nm1, nm1);
        k = k + hjs_pkg::CNT_W'(1);
      end
    end
    if (bot_en) begin
      if (col_n == NW'(2)) begin
        item_d.desc.slot[k] = make_slot(hjs_pkg::SRC_BOTTOM, row_n, '0, nm1);
        k = k + hjs_pkg::CNT_W'(1);
      end else if (pend_q) begin
        item_d.desc.slot[k] = make_slot(hjs_pkg::SRC_HELD, row_n, col_n - NW'(2), nm1);
        k = k + hjs_pkg::CNT_W'(1);
      end
      if (last_col) begin
        item_d.desc.slot[k] = make_slot(hjs_pkg::SRC_BOTTOM, row_n, nm2, nm1);
        k = k + hjs_pkg::CNT_W'(1);
        item_d.desc.slot[k] = make_slot(hjs_pkg::SRC_BOTTOM, row_n, nm1, nm1);
        k = k + hjs_pkg::CNT_W'(1);
      end else begin
        item_d.desc.upd_held = 1'b1;
      end
    end
    item_d.desc.count = k;
  end

  // Items that cause no result and leave no held value stop here.
  assign keep = (item_d.desc.count != '0) || item_d.desc.upd_held;

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = keep;
    end else if (item_ready_i) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= 1'b0;
      left_q <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
      s1_v_q <= s1_v_d;
      if (accept) begin
        left_q <= rd_mid0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q <= cell_temperature_i;
      x2_q <= x1_q;
      s1_q <= item_d;
    end
  end

  assign item_valid_o = s1_v_q;
  assign item_o       = s1_q;

endmodule

// ===== rtl/hjs_stencil_back.sv =====
// ----------------------------------------------------------------------------
// hjs_stencil_back: weight, rounding and result delivery
// Multiplies the neighbor sums by the gain, rounds and saturates them, and
// hands the planned results out of a result register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module hjs_stencil_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [hjs_pkg::ALPHA_W-1:0]  alpha_i,
  input  logic                         item_valid_i,
  input  hjs_pkg::front_item_t         item_i,
  output logic                         item_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hjs_pkg::DATA_W-1:0]   new_temperature_o,
  output logic [hjs_pkg::ROWCOL_W-1:0] out_row_o,
  output logic [hjs_pkg::ROWCOL_W-1:0] out_column_o,
  output logic                         last_of_run_o,
  output logic                         sweep_done_o
);

  logic                        s2_v_q, s2_v_d, s2_ready, s2_adv, s1_adv;
  hjs_pkg::desc_t              s2_desc_q;
  logic [hjs_pkg::PROD_W-1:0]  prod_int_q, prod_bot_q;
  logic signed [hjs_pkg::PROD_W-1:0] prod_int, prod_bot;

  logic                        s3_v_q, s3_v_d, s3_free, out_fire, slot_last;
  hjs_pkg::desc_t              s3_desc_q;
  logic [hjs_pkg::DATA_W-1:0]  val_q [hjs_pkg::SLOTS];
  logic [hjs_pkg::DATA_W-1:0]  val_d [hjs_pkg::SLOTS];
  logic [hjs_pkg::CNT_W-1:0]   idx_q, idx_d;
  logic [hjs_pkg::DATA_W-1:0]  held_q, iv, bv;

  assign out_fire  = s3_v_q && !out_stall_i;
  assign slot_last = (idx_q == s3_desc_q.count - hjs_pkg::CNT_W'(1));
  assign s3_free   = !s3_v_q || (out_fire && slot_last);
  assign s2_adv    = s2_v_q && s3_free;
  assign s2_ready  = !s2_v_q || s2_adv;
  assign s1_adv    = item_valid_i && s2_ready;
  assign item_ready_o = s2_ready;

  assign prod_int = $signed(item_i.sum_int) * $signed({1'b0, alpha_i});
  assign prod_bot = $signed(item_i.sum_bot) * $signed({1'b0, alpha_i});

  always_comb begin
    s2_v_d = s2_v_q;
    if (s1_adv) begin
      s2_v_d = 1'b1;
    end else if (s2_adv) begin
      s2_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_desc_q  <= item_i.desc;
      prod_int_q <= prod_int;
      prod_bot_q <= prod_bot;
    end
  end

  assign iv = hjs_pkg::round_sat(prod_int_q);
  assign bv = hjs_pkg::round_sat(prod_bot_q);

  always_comb begin
    for (int i = 0; i < hjs_pkg::SLOTS; i++) begin
      case (s2_desc_q.slot[i].src)
        hjs_pkg::SRC_INTERIOR: val_d[i] = iv;
        hjs_pkg::SRC_BOTTOM:   val_d[i] = bv;
        hjs_pkg::SRC_HELD:     val_d[i] = held_q;
        default:               val_d[i] = iv;
      endcase
    end
  end

  always_comb begin
    s3_v_d = s3_v_q;
    idx_d  = idx_q;
    if (s3_free) begin
      s3_v_d = s2_adv && (s2_desc_q.count != '0);
      idx_d  = '0;
    end else if (out_fire) begin
      idx_d = idx_q + hjs_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      idx_q  <= '0;
      held_q <= '0;
    end else begin
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
      idx_q  <= idx_d;
      // The bottom value of this item is emitted with the next one.
      if (s2_adv && s2_desc_q.upd_held) begin
        held_q <= bv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_desc_q <= s2_desc_q;
      val_q     <= val_d;
    end
  end

  assign out_valid_o       = s3_v_q;
  assign new_temperature_o = val_q[idx_q];
  assign out_row_o         = s3_desc_q.slot[idx_q].row;
  assign out_column_o      = s3_desc_q.slot[idx_q].col;
  assign sweep_done_o      = s3_desc_q.slot[idx_q].done;
  assign last_of_run_o     = slot_last;

endmodule

// ===== rtl/heat_jacobi_stencil_sweep_unit.sv =====
// ----------------------------------------------------------------------------
// heat_jacobi_stencil_sweep_unit: one Jacobi sweep of the five-point heat stencil
// Grid cells enter in raster order, one item per clock cycle at most, and each
// item is accepted while earlier ones are still in flight. An item passes an
// operand stage (line buffer reads and neighbor sums), a multiply stage and a
// rounding stage, whose result register drives the result port. Each item
// causes zero to three results, and the result port delivers one per cycle
// while it is not stalled; that port sets the sustained rate. Over a whole
// sweep there is one result per item, yet the pipeline has no slack: in each
// row below the top, the extra results of the column-one and next-to-last
// column items can stall the input, and the last row yields about two results
// per item and can stall it too. Line buffers need no clearing pass after reset.
// Writing the grid size restarts the sweep at row 0, column 0 with the next item.
// ----------------------------------------------------------------------------
module heat_jacobi_stencil_sweep_unit #(
  parameter int GRID_MAX = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [hjs_pkg::DATA_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hjs_pkg::DATA_W-1:0]   cell_temperature_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hjs_pkg::DATA_W-1:0]   new_temperature_o,
  output logic [hjs_pkg::ROWCOL_W-1:0] out_row_o,
  output logic [hjs_pkg::ROWCOL_W-1:0] out_column_o,
  output logic                         last_of_run_o,
  output logic                         sweep_done_o
);

  hjs_pkg::cfg_t        cfg;
  logic                 grid_wr;
  logic                 item_valid, item_ready;
  hjs_pkg::front_item_t item;

  hjs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .grid_wr_o   (grid_wr)
  );

  hjs_line_front #(
    .GRID_MAX (GRID_MAX)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .grid_wr_i          (grid_wr),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cell_temperature_i (cell_temperature_i),
    .item_valid_o       (item_valid),
    .item_o             (item),
    .item_ready_i       (item_ready)
  );

  hjs_stencil_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .alpha_i           (cfg.alpha),
    .item_valid_i      (item_valid),
    .item_i            (item),
    .item_ready_o      (item_ready),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .new_temperature_o (new_temperature_o),
    .out_row_o         (out_row_o),
    .out_column_o      (out_column_o),
    .last_of_run_o     (last_of_run_o),
    .sweep_done_o      (sweep_done_o)
  );

endmodule

// ===== rtl/hjs_port_checker.sv =====
// ----------------------------------------------------------------------------
// hjs_port_checker: port-level checks of the stencil sweep unit
// Watches the result channel and the input stall over time.
// ----------------------------------------------------------------------------
module hjs_port_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [hjs_pkg::DATA_W-1:0]   new_temperature_o,
  input logic [hjs_pkg::ROWCOL_W-1:0] out_row_o,
  input logic [hjs_pkg::ROWCOL_W-1:0] out_column_o,
  input logic                         last_of_run_o,
  input logic                         sweep_done_o
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_temperature_o) &&
      $stable(out_row_o) && $stable(out_column_o) && $stable(last_of_run_o))
    else $error("stalled result changed or vanished");

  // The results of one item leave without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside the results of one item");

  // The final cell of the sweep is the last result of its item, on the diagonal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sweep_done_o |-> last_of_run_o && (out_row_o == out_column_o))
    else $error("sweep end flagged on the wrong result");

  // The input only stalls while results are backed up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule

bind heat_jacobi_stencil_sweep_unit hjs_port_checker u_port_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .new_temperature_o (new_temperature_o),
  .out_row_o         (out_row_o),
  .out_column_o      (out_column_o),
  .last_of_run_o     (last_of_run_o),
  .sweep_done_o      (sweep_done_o)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the Jacobi heat stencil sweep unit
// Streams grid cells through the unit under several register settings and
// idle patterns, predicts every updated cell with an independent model of
// the sweep, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hjs_pkg::*;

  localparam int GRID_CAP   = 1024;
  localparam int SETTLE     = 12;
  localparam int QUIET_MAX  = 2000;

  typedef struct packed {
    logic [DATA_W-1:0]   temp;
    logic [ROWCOL_W-1:0] row;
    logic [ROWCOL_W-1:0] col;
    logic                last;
    logic                done;
  } cell_update_t;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_valid_i        = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i        = REG_GRID_SIZE;
  logic [DATA_W-1:0]   cfg_data_i         = '0;
  logic                in_valid_i         = 1'b0;
  logic                in_stall_o;
  logic [DATA_W-1:0]   cell_temperature_i = '0;
  logic                out_valid_o;
  logic                out_stall_i        = 1'b0;
  logic [DATA_W-1:0]   new_temperature_o;
  logic [ROWCOL_W-1:0] out_row_o;
  logic [ROWCOL_W-1:0] out_column_o;
  logic                last_of_run_o;
  logic                sweep_done_o;

  heat_jacobi_stencil_sweep_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .cell_temperature_i,
    .out_valid_o,
    .out_stall_i,
    .new_temperature_o,
    .out_row_o,
    .out_column_o,
    .last_of_run_o,
    .sweep_done_o
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the sweep state.
  logic [GRID_W-1:0]  grid_reg  = GRID_RESET;
  logic [ALPHA_W-1:0] alpha_reg = ALPHA_RESET;
  logic signed [31:0] hot_reg   = HOT_RESET;
  logic signed [31:0] cold_reg  = COLD_RESET;
  logic signed [31:0] row_above [GRID_CAP];
  logic signed [31:0] row_mid   [GRID_CAP];
  logic signed [31:0] west_cell    = '0;
  logic signed [31:0] held_bottom  = '0;
  logic               held_pending = 1'b0;
  int unsigned        cur_row      = 0;
  int unsigned        cur_col      = 0;

  cell_update_t updated_cells[$];
  int           mismatch_count  = 0;
  int           sender_idle_pct = 0;
  int           stall_pct       = 0;
  int unsigned  quiet_cycles    = 0;

  initial begin
    for (int i = 0; i < GRID_CAP; i++) begin
      row_above[i] = '0;
      row_mid[i]   = '0;
    end
  end

  function automatic int unsigned edge_cells(input logic [GRID_W-1:0] g);
    if (g < 3) begin
      return 3;
    end
    if (g > GRID_CAP) begin
      return GRID_CAP;
    end
    return 32'(g);
  endfunction

  // Sum of four neighbors times alpha, rounded half up and saturated.
  function automatic logic [DATA_W-1:0] diffuse(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic signed [31:0] c,
                                                input logic signed [31:0] d);
    longint total;
    longint prod;
    longint q;
    total = longint'(a) + longint'(b) + longint'(c) + longint'(d);
    prod  = total * longint'({48'd0, alpha_reg});
    q     = (prod + 64'sd32768) >>> 16;
    if (q > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (q < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  function automatic void add_update(input logic [DATA_W-1:0] v, input int unsigned row,
                                     input int unsigned col, input int unsigned n);
    cell_update_t u;
    u.temp = v;
    u.row  = row[ROWCOL_W-1:0];
    u.col  = col[ROWCOL_W-1:0];
    u.last = 1'b0;
    u.done = (row == n - 1) && (col == n - 1);
    updated_cells.push_back(u);
  endfunction

  function automatic void apply_setting(input cfg_reg_e idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_GRID_SIZE: begin
        grid_reg     = val[GRID_W-1:0];
        cur_row      = 0;
        cur_col      = 0;
        held_pending = 1'b0;
      end
      REG_ALPHA_GAIN: alpha_reg = val[ALPHA_W-1:0];
      REG_HOT_TEMP:   hot_reg   = val;
      REG_COLD_TEMP:  cold_reg  = val;
      default: ;
    endcase
  endfunction

  // Works out the updates that one incoming cell releases.
  function automatic void sweep_cell(input logic signed [31:0] x);
    int unsigned        n;
    int unsigned        r;
    int unsigned        c;
    int                 first;
    logic signed [31:0] up;
    logic [DATA_W-1:0]  v;
    n     = edge_cells(grid_reg);
    r     = cur_row;
    c     = cur_col;
    first = updated_cells.size();
    if (r >= n) r = 0;
    if (c >= n) c = 0;
    if (r >= 1 && c >= 1 && c <= n - 2) begin
      up = (r == 1) ? hot_reg : row_above[c];
      v  = diffuse(up, x, west_cell, row_mid[c+1]);
      if (c == 1) add_update(v, r - 1, 0, n);
      add_update(v, r - 1, c, n);
      if (c == n - 2) add_update(v, r - 1, n - 1, n);
    end
    // The bottom row trails the input by one column, so one value is held back.
    if (r == n - 1 && c >= 2) begin
      v = diffuse(row_above[c-1], cold_reg, row_mid[c-2], x);
      if (c == 2) begin
        add_update(v, r, 0, n);
      end else if (held_pending) begin
        add_update(held_bottom, r, c - 2, n);
      end
      if (c == n - 1) begin
        add_update(v, r, n - 2, n);
        add_update(v, r, n - 1, n);
        held_pending = 1'b0;
      end else begin
        held_bottom  = v;
        held_pending = 1'b1;
      end
    end
    west_cell    = row_mid[c];
    row_above[c] = west_cell;
    row_mid[c]   = x;
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    cur_row = r;
    cur_col = c;
    if (updated_cells.size() > first) begin
      updated_cells[updated_cells.size()-1].last = 1'b1;
    end
  endfunction

  function automatic logic [DATA_W-1:0] random_temp();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(26214400) - 32'd13107200;
      2: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(131072) - 32'd65536;
    endcase
  endfunction

  function automatic logic [ALPHA_W-1:0] random_alpha();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return ALPHA_RESET;
      default: return ALPHA_W'($urandom_range(65535));
    endcase
  endfunction

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Outputs settle by the falling edge, so handshakes are judged there.
  always @(negedge clk_i) begin
    cell_update_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (updated_cells.size() == 0) begin
        $error("unexpected result: row %0d column %0d value %h",
               out_row_o, out_column_o, new_temperature_o);
        mismatch_count++;
      end else begin
        want = updated_cells.pop_front();
        if (new_temperature_o !== want.temp) begin
          $error("new_temperature: expected %h, got %h", want.temp, new_temperature_o);
          mismatch_count++;
        end
        if (out_row_o !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row_o);
          mismatch_count++;
        end
        if (out_column_o !== want.col) begin
          $error("out_column: expected %0d, got %0d", want.col, out_column_o);
          mismatch_count++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run_o);
          mismatch_count++;
        end
        if (sweep_done_o !== want.done) begin
          $error("sweep_done: expected %0b, got %0b", want.done, sweep_done_o);
          mismatch_count++;
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_cell(input logic [DATA_W-1:0] t);
    logic taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cell_temperature_i <= t;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sweep_cell(t);
  endtask

  task automatic wait_results(input int settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (updated_cells.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DATA_W-1:0] val);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    apply_setting(idx, val);
  endtask

  task automatic configure(input logic [GRID_W-1:0] g, input logic [ALPHA_W-1:0] a,
                           input logic [DATA_W-1:0] h, input logic [DATA_W-1:0] c);
    wait_results(SETTLE);
    write_reg(REG_GRID_SIZE, DATA_W'(g));
    write_reg(REG_ALPHA_GAIN, DATA_W'(a));
    write_reg(REG_HOT_TEMP, h);
    write_reg(REG_COLD_TEMP, c);
    cfg_valid_i <= 1'b0;
  endtask

  // Only the grid size is written, so the other registers keep their reset values.
  task automatic test_reset_defaults();
    wait_results(SETTLE);
    write_reg(REG_GRID_SIZE, 32'd3);
    cfg_valid_i <= 1'b0;
    for (int k = 0; k < 9; k++) begin
      send_cell(32'd6553600 - k * 32'd655360);
    end
  endtask

  task automatic test_extremes();
    logic [DATA_W-1:0] cells [9];
    cells = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
    configure(11'd0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    foreach (cells[k]) begin
      send_cell(cells[k]);
    end
  endtask

  // A weight of one half puts odd sums exactly on the rounding tie; odd hot and cold make such sums.
  task automatic test_rounding_ties();
    configure(11'd1, 16'd32768, 32'd1, 32'hFFFF_FFFF);
    for (int k = 0; k < 9; k++) begin
      send_cell((k % 2 == 0) ? 32'(k + 2) : -32'(k + 1));
    end
  endtask

  task automatic test_sweep_wrap();
    configure(11'd4, ALPHA_RESET, HOT_RESET, COLD_RESET);
    for (int k = 0; k < 16; k++) begin
      send_cell(random_temp());
    end
    // Hold the next sweep back until the first one has fully drained.
    wait_results(0);
    for (int k = 0; k < 16; k++) begin
      send_cell(random_temp());
    end
  endtask

  // Rewriting the grid size mid bottom row drops the held value.
  task automatic test_restart();
    configure(11'd5, random_alpha(), random_temp(), random_temp());
    for (int k = 0; k < 23; k++) begin
      send_cell(random_temp());
    end
    configure(11'd6, random_alpha(), random_temp(), random_temp());
    for (int k = 0; k < 36; k++) begin
      send_cell(random_temp());
    end
  endtask

  task automatic test_wide_grid();
    sender_idle_pct = 18;
    stall_pct       = 18;
    configure(11'd1024, random_alpha(), random_temp(), random_temp());
    for (int k = 0; k < 3; k++) begin
      send_cell(random_temp());
    end
    configure(11'd2047, random_alpha(), random_temp(), random_temp());
    for (int k = 0; k < 3; k++) begin
      send_cell(random_temp());
    end
  endtask

  task automatic test_random_sweeps(input int idle, input int stall, input int budget);
    int          sent;
    int unsigned n;
    int          cells;
    int          pause_at;
    logic [GRID_W-1:0] g;
    sender_idle_pct = idle;
    stall_pct       = stall;
    sent            = 0;
    while (sent < budget) begin
      g = GRID_W'(($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(9, 3));
      configure(g, random_alpha(), random_temp(), random_temp());
      n     = edge_cells(g);
      cells = n * n * (1 + $urandom_range(1));
      if ($urandom_range(4) == 0) begin
        cells = $urandom_range(n * n - 1, 1);
      end
      if (cells > budget - sent) begin
        cells = budget - sent;
      end
      pause_at = ($urandom_range(2) == 0) ? $urandom_range(cells - 1) : -1;
      for (int k = 0; k < cells; k++) begin
        if (k == pause_at) begin
          wait_results(0);
        end
        send_cell(random_temp());
      end
      sent += cells;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_rounding_ties();
    test_sweep_wrap();
    test_restart();
    test_wide_grid();
    test_random_sweeps(0, 0, 84);
    test_random_sweeps(68, 0, 84);
    test_random_sweeps(0, 68, 84);
    test_random_sweeps(18, 18, 84);
    wait_results(SETTLE);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hjs_pkg.sv
rtl/hjs_cfg_regs.sv
rtl/hjs_line_front.sv
rtl/hjs_stencil_back.sv
rtl/heat_jacobi_stencil_sweep_unit.sv
rtl/hjs_port_checker.sv
dv/testbench.sv
